/* rtl/core/slsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_pkg
// Shared types, constants and tables for the spherical lens source mapper.
// ----------------------------------------------------------------------------
package slsc_pkg;

	localparam int DEF_MAX_DIM = 4096;

	// CORDIC setup, angles in Q16 radians
	localparam int CORDIC_N    = 16;
	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int ROT_X0      = 1 << 20;

	typedef enum logic [1:0] {
		REG_NUM_ROWS    = 2'd0,
		REG_NUM_COLS    = 2'd1,
		REG_LENS_FACTOR = 2'd2
	} reg_idx_t;

	// per-beat data carried down the whole pipe
	typedef struct packed {
		logic               in_lens;
		logic [11:0]        row;
		logic [11:0]        col;
		logic signed [12:0] dr;
		logic signed [12:0] dc;
		logic [19:0]        z8;
	} sb_t;

	// divider side flags, one set per axis
	typedef struct packed {
		logic pole;   // cx <= 0
		logic cypos;  // cy > 0
		logic neg;    // numerator negative
		logic sat;    // quotient at least 2^23
	} dflg_t;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic        in_lens;
		logic        clamped;
	} res_t;

	function automatic logic [16:0] atan_q16(input int n);
		logic [16:0] r;
		unique case (n)
			0:  r = 17'd51472;
			1:  r = 17'd30386;
			2:  r = 17'd16055;
			3:  r = 17'd8150;
			4:  r = 17'd4091;
			5:  r = 17'd2047;
			6:  r = 17'd1024;
			7:  r = 17'd512;
			8:  r = 17'd256;
			9:  r = 17'd128;
			10: r = 17'd64;
			11: r = 17'd32;
			12: r = 17'd16;
			13: r = 17'd8;
			14: r = 17'd4;
			15: r = 17'd2;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/spherical_lens_source_coord.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_lens_source_coord
// Maps a destination pixel to the source pixel of a spherical lens effect.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat
//  dest      in         dest_valid / dest_ready   dest_row, dest_col
//  src       out        src_valid / src_ready     src_row, src_col,
//                                                 inside_lens, clamped
//  apb       in         psel/penable/pwrite       paddr, pwdata -> prdata
//
//  One beat enters per clock while the output buffer has a free slot.
//  The depth is set by the digit-serial square root (20 stages), the two
//  16-step CORDICs and the 23-step restoring divider for the tangent offset.
//  A two-entry output buffer takes results; the whole pipe freezes only when
//  that buffer is full, so no beat is lost or repeated during stalls.
//  arst_n clears valid bits, buffer pointers and the registers to their
//  reset values (512 x 512, lens factor zero).
// ----------------------------------------------------------------------------
module spherical_lens_source_coord
	import slsc_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dest_valid,
	output logic        dest_ready,
	input  logic [11:0] dest_row,
	input  logic [11:0] dest_col,
	output logic        src_valid,
	input  logic        src_ready,
	output logic [11:0] src_row,
	output logic [11:0] src_col,
	output logic        inside_lens,
	output logic        clamped,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// stage map
	localparam int ST_MUL  = 2;                // squares
	localparam int ST_RAD  = 3;                // inside test, radicand
	localparam int SQ0     = 4;
	localparam int SQN     = 20;
	localparam int SQ_LAST = SQ0 + SQN - 1;
	localparam int VC0     = SQ_LAST + 1;
	localparam int VC_LAST = VC0 + CORDIC_N - 1;
	localparam int ST_KMUL = VC_LAST + 1;
	localparam int RD0     = ST_KMUL + 1;
	localparam int RD_LAST = RD0 + 2;
	localparam int RT0     = RD_LAST + 1;
	localparam int RT_LAST = RT0 + CORDIC_N - 1;
	localparam int ST_NMUL = RT_LAST + 1;
	localparam int ST_PREP = ST_NMUL + 1;
	localparam int DV0     = ST_PREP + 1;
	localparam int DVN     = 23;
	localparam int LAST    = DV0 + DVN - 1;

	localparam int CW  = 31;  // vectoring datapath
	localparam int AW  = 19;  // angle accumulator
	localparam int RW  = 24;  // rotation datapath
	localparam int RBW = 19;  // rotation residual angle
	localparam int MAX_HI = MAX_DIM - 1;

	// ---------------- configuration ----------------
	logic [12:0]        num_rows_q;
	logic [12:0]        num_cols_q;
	logic signed [19:0] lens_factor_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q    <= 13'd512;
			num_cols_q    <= 13'd512;
			lens_factor_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_NUM_ROWS:    num_rows_q    <= pwdata[12:0];
				REG_NUM_COLS:    num_cols_q    <= pwdata[12:0];
				REG_LENS_FACTOR: lens_factor_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_NUM_ROWS:    prdata = {19'd0, num_rows_q};
			REG_NUM_COLS:    prdata = {19'd0, num_cols_q};
			REG_LENS_FACTOR: prdata = {{12{lens_factor_q[19]}}, lens_factor_q};
			default:         prdata = '0;
		endcase
	end

	function automatic logic [12:0] bound_of(input logic [12:0] size);
		logic [12:0] szm1;
		szm1 = (size == 13'd0) ? 13'd0 : size - 13'd1;
		if (MAX_HI < int'(szm1))
			return 13'(MAX_HI);
		return szm1;
	endfunction

	// ---------------- flow control ----------------
	// the pipe moves whenever the output buffer has a free slot
	logic       pipe_en;
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	res_t       buf_q [2];
	res_t       res_c;
	logic       push;
	logic       pop;

	logic vld_s [1:LAST];
	sb_t  sb_s  [1:LAST];

	assign pipe_en    = (cnt_q != 2'd2);
	assign dest_ready = pipe_en;
	assign push       = pipe_en & vld_s[LAST];
	assign src_valid  = (cnt_q != 2'd0);
	assign pop        = src_valid & src_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++)
				vld_s[i] <= 1'b0;
		end else if (pipe_en) begin
			vld_s[1] <= dest_valid;
			for (int i = 2; i <= LAST; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	// ---------------- stage 1: centre and offsets ----------------
	logic [11:0] mid_r;
	logic [11:0] mid_c;
	logic [11:0] rad_s1;
	sb_t         sb_in;

	assign mid_r = num_rows_q[12:1];
	assign mid_c = num_cols_q[12:1];

	always_comb begin
		sb_in        = '0;
		sb_in.row    = dest_row;
		sb_in.col    = dest_col;
		sb_in.dr     = 13'($signed({1'b0, dest_row}) - $signed({1'b0, mid_r}));
		sb_in.dc     = 13'($signed({1'b0, dest_col}) - $signed({1'b0, mid_c}));
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sb_s[1] <= sb_in;
			rad_s1  <= (mid_r < mid_c) ? mid_r : mid_c;
		end
	end

	// ---------------- stage 2: squares ----------------
	logic signed [25:0] sqr_r;
	logic signed [25:0] sqr_c;
	logic [25:0]        dist2_s2;
	logic [23:0]        rad2_s2;

	assign sqr_r = sb_s[1].dr * sb_s[1].dr;
	assign sqr_c = sb_s[1].dc * sb_s[1].dc;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dist2_s2 <= 26'(sqr_r) + 26'(sqr_c);
			rad2_s2  <= rad_s1 * rad_s1;
		end
	end

	// ---------------- stage 3: inside test ----------------
	logic        inside_c;
	logic [23:0] rdc_s3;

	assign inside_c = dist2_s2 < {2'b00, rad2_s2};

	always_ff @(posedge clk) begin
		if (pipe_en)
			rdc_s3 <= inside_c ? 24'({2'b00, rad2_s2} - dist2_s2) : 24'd0;
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [21:0] sq_rem_s  [SQ0:SQ_LAST];
	logic [19:0] sq_root_s [SQ0:SQ_LAST];
	logic [23:0] sq_rad_s  [SQ0:SQ_LAST];
	logic [19:0] z8_c;

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		logic [21:0] rem_in;
		logic [19:0] root_in;
		logic [23:0] rad_in;
		logic [39:0] v;
		logic [23:0] t;
		logic [23:0] test;
		logic        ge;
		logic [19:0] root_out;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rdc_s3;
		end else begin : g_next
			assign rem_in  = sq_rem_s[SQ0+k-1];
			assign root_in = sq_root_s[SQ0+k-1];
			assign rad_in  = sq_rad_s[SQ0+k-1];
		end

		assign v        = {rad_in, 16'd0};
		assign t        = {rem_in, v[39-2*k -: 2]};
		assign test     = {2'b00, root_in, 2'b01};
		assign ge       = t >= test;
		assign root_out = {root_in[18:0], ge};

		if (k == SQN - 1) begin : g_out
			assign z8_c = root_out;
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				sq_rem_s[SQ0+k]  <= ge ? 22'(t - test) : 22'(t);
				sq_root_s[SQ0+k] <= root_out;
				sq_rad_s[SQ0+k]  <= rad_in;
			end
		end
	end

	// sideband copy, with fields filled in where they are found
	for (genvar i = 2; i <= LAST; i++) begin : g_sb
		sb_t nx;
		always_comb begin
			nx = sb_s[i-1];
			if (i == ST_RAD)
				nx.in_lens = inside_c;
			if (i == SQ_LAST)
				nx.z8 = z8_c;
		end
		always_ff @(posedge clk) begin
			if (pipe_en)
				sb_s[i] <= nx;
		end
	end

	// ---------------- per-axis lanes: row (0) and column (1) ----------------
	logic [11:0] lane_src [2];
	logic        lane_hit [2];
	logic [12:0] hi_r;
	logic [12:0] hi_c;

	assign hi_r = bound_of(num_rows_q);
	assign hi_c = bound_of(num_cols_q);

	for (genvar L = 0; L < 2; L++) begin : g_lane
		// vectoring CORDIC: angle of (z, d)
		logic signed [CW-1:0] vx_s  [VC0:VC_LAST];
		logic signed [CW-1:0] vy_s  [VC0:VC_LAST];
		logic signed [AW-1:0] ang_s [VC0:VC_LAST];

		for (genvar n = 0; n < CORDIC_N; n++) begin : g_vec
			logic signed [CW-1:0] x_in;
			logic signed [CW-1:0] y_in;
			logic signed [AW-1:0] a_in;
			logic signed [AW-1:0] at;
			logic signed [12:0]   d;

			assign d = (L == 0) ? sb_s[VC0-1].dr : sb_s[VC0-1].dc;
			assign at = $signed({2'b00, atan_q16(n)});

			if (n == 0) begin : g_first
				assign x_in = $signed(CW'({sb_s[VC0-1].z8, 8'd0}));
				assign y_in = $signed(CW'(d)) <<< 16;
				assign a_in = '0;
			end else begin : g_next
				assign x_in = vx_s[VC0+n-1];
				assign y_in = vy_s[VC0+n-1];
				assign a_in = ang_s[VC0+n-1];
			end

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					if (y_in >= 0) begin
						vx_s[VC0+n]  <= x_in + (y_in >>> n);
						vy_s[VC0+n]  <= y_in - (x_in >>> n);
						ang_s[VC0+n] <= a_in + at;
					end else begin
						vx_s[VC0+n]  <= x_in - (y_in >>> n);
						vy_s[VC0+n]  <= y_in + (x_in >>> n);
						ang_s[VC0+n] <= a_in - at;
					end
				end
			end
		end

		// bend angle by the lens factor
		logic signed [38:0] prod_s;
		always_ff @(posedge clk) begin
			if (pipe_en)
				prod_s <= ang_s[VC_LAST] * lens_factor_q;
		end

		// fold into [-pi/2, pi/2) by 4, 2 and 1 multiples of pi
		logic signed [22:0] red_s [RD0:RD_LAST];
		for (genvar r = 0; r < 3; r++) begin : g_red
			localparam int M  = 4 >> r;
			localparam int UP = HALF_PI_Q16 + (M - 1) * PI_Q16;
			localparam int LO = -HALF_PI_Q16 - (M - 1) * PI_Q16;
			localparam int MP = M * PI_Q16;
			logic signed [22:0] b_in;

			if (r == 0) begin : g_first
				assign b_in = 23'(prod_s >>> 16);
			end else begin : g_next
				assign b_in = red_s[RD0+r-1];
			end

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					if (b_in >= $signed(23'(UP)))
						red_s[RD0+r] <= b_in - $signed(23'(MP));
					else if (b_in < $signed(23'(LO)))
						red_s[RD0+r] <= b_in + $signed(23'(MP));
					else
						red_s[RD0+r] <= b_in;
				end
			end
		end

		// rotation CORDIC: (cos, sin) of the bend angle
		logic signed [RW-1:0]  cx_s [RT0:RT_LAST];
		logic signed [RW-1:0]  cy_s [RT0:RT_LAST];
		logic signed [RBW-1:0] rb_s [RT0:RT_LAST];

		for (genvar n = 0; n < CORDIC_N; n++) begin : g_rot
			logic signed [RW-1:0]  x_in;
			logic signed [RW-1:0]  y_in;
			logic signed [RBW-1:0] b_in;
			logic signed [RBW-1:0] at;

			assign at = $signed({2'b00, atan_q16(n)});

			if (n == 0) begin : g_first
				assign x_in = $signed(RW'(ROT_X0));
				assign y_in = '0;
				assign b_in = RBW'(red_s[RD_LAST]);
			end else begin : g_next
				assign x_in = cx_s[RT0+n-1];
				assign y_in = cy_s[RT0+n-1];
				assign b_in = rb_s[RT0+n-1];
			end

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					if (b_in >= 0) begin
						cx_s[RT0+n] <= x_in - (y_in >>> n);
						cy_s[RT0+n] <= y_in + (x_in >>> n);
						rb_s[RT0+n] <= b_in - at;
					end else begin
						cx_s[RT0+n] <= x_in + (y_in >>> n);
						cy_s[RT0+n] <= y_in - (x_in >>> n);
						rb_s[RT0+n] <= b_in + at;
					end
				end
			end
		end

		// numerator z * sin, denominator cos and the pole flags
		logic signed [43:0]   num_s;
		logic signed [RW-1:0] den_s;
		logic                 pole_s;
		logic                 cypos_s;

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				num_s   <= 44'($signed({1'b0, sb_s[ST_NMUL-1].z8}) * cy_s[RT_LAST]);
				den_s   <= cx_s[RT_LAST];
				pole_s  <= cx_s[RT_LAST] <= 0;
				cypos_s <= cy_s[RT_LAST] > 0;
			end
		end

		// divider setup: magnitude, saturation test
		logic [43:0] abs_n;
		logic [23:0] pre_rem_s;
		logic [22:0] pre_lo_s;
		logic [23:0] pre_den_s;
		dflg_t       pre_flg_s;

		assign abs_n = num_s[43] ? 44'(-num_s) : 44'(num_s);

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				pre_rem_s       <= 24'(abs_n[43:23]);
				pre_lo_s        <= abs_n[22:0];
				pre_den_s       <= den_s;
				pre_flg_s.pole  <= pole_s;
				pre_flg_s.cypos <= cypos_s;
				pre_flg_s.neg   <= num_s[43];
				pre_flg_s.sat   <= {3'b000, abs_n[43:23]} >= 24'(den_s);
			end
		end

		// restoring divider, one quotient bit per stage
		logic [23:0] drem_s [DV0:LAST];
		logic [22:0] dq_s   [DV0:LAST];
		logic [22:0] dlo_s  [DV0:LAST];
		logic [23:0] dden_s [DV0:LAST];
		dflg_t       dflg_s [DV0:LAST];

		for (genvar j = 0; j < DVN; j++) begin : g_div
			logic [23:0] rem_in;
			logic [22:0] q_in;
			logic [22:0] lo_in;
			logic [23:0] den_in;
			dflg_t       flg_in;
			logic [24:0] t;
			logic        ge;

			if (j == 0) begin : g_first
				assign rem_in = pre_rem_s;
				assign q_in   = '0;
				assign lo_in  = pre_lo_s;
				assign den_in = pre_den_s;
				assign flg_in = pre_flg_s;
			end else begin : g_next
				assign rem_in = drem_s[DV0+j-1];
				assign q_in   = dq_s[DV0+j-1];
				assign lo_in  = dlo_s[DV0+j-1];
				assign den_in = dden_s[DV0+j-1];
				assign flg_in = dflg_s[DV0+j-1];
			end

			assign t  = {rem_in, lo_in[DVN-1-j]};
			assign ge = t >= {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					drem_s[DV0+j] <= ge ? 24'(t - {1'b0, den_in}) : 24'(t);
					dq_s[DV0+j]   <= {q_in[21:0], ge};
					dlo_s[DV0+j]  <= lo_in;
					dden_s[DV0+j] <= den_in;
					dflg_s[DV0+j] <= flg_in;
				end
			end
		end

		// source = round(pos - offset), then clamp
		logic [11:0]        pos;
		logic [12:0]        hi;
		logic [23:0]        off_mag;
		logic signed [24:0] off;
		logic signed [26:0] s;
		logic signed [18:0] srcv;
		logic [12:0]        src;
		logic               hit;
		dflg_t              f;

		assign f       = dflg_s[LAST];
		assign pos     = (L == 0) ? sb_s[LAST].row : sb_s[LAST].col;
		assign hi      = (L == 0) ? hi_r : hi_c;
		assign off_mag = f.sat ? 24'h800000 : {1'b0, dq_s[LAST]};
		assign off     = f.neg ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
		assign s       = $signed({7'd0, pos, 8'd0}) - 27'(off) + 27'sd128;
		assign srcv    = 19'(s >>> 8);

		always_comb begin
			hit = 1'b1;
			if (f.pole)
				src = f.cypos ? 13'd0 : hi;
			else if (srcv < 0)
				src = 13'd0;
			else if (srcv > $signed({6'd0, hi}))
				src = hi;
			else begin
				src = srcv[12:0];
				hit = 1'b0;
			end
		end

		assign lane_src[L] = src[11:0];
		assign lane_hit[L] = hit;
	end

	// ---------------- result and output buffer ----------------
	always_comb begin
		res_c.in_lens = sb_s[LAST].in_lens;
		if (sb_s[LAST].in_lens) begin
			res_c.row     = lane_src[0];
			res_c.col     = lane_src[1];
			res_c.clamped = lane_hit[0] | lane_hit[1];
		end else begin
			res_c.row     = sb_s[LAST].row;
			res_c.col     = sb_s[LAST].col;
			res_c.clamped = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= res_c;
	end

	assign src_row     = buf_q[rd_ptr_q].row;
	assign src_col     = buf_q[rd_ptr_q].col;
	assign inside_lens = buf_q[rd_ptr_q].in_lens;
	assign clamped     = buf_q[rd_ptr_q].clamped;

endmodule

/* tb/slsc_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_scoreboard
// Predicts the source coordinate of each accepted destination beat and
// checks the results of the lens mapper in order.
// ----------------------------------------------------------------------------
class slsc_scoreboard;

	localparam int STEPS = 16;
	localparam longint PI_FX = 205887;
	localparam longint HALF_PI_FX = 102944;

	typedef struct {
		logic [11:0] row;
		logic [11:0] col;
		logic        in_lens;
		logic        clamped;
	} coord_t;

	logic [12:0]        rows_cfg;
	logic [12:0]        cols_cfg;
	logic signed [19:0] k_cfg;
	coord_t             pending[$];
	int                 errors;

	function new();
		rows_cfg = 13'd512;
		cols_cfg = 13'd512;
		k_cfg = '0;
		errors = 0;
	endfunction

	function void set_reg(int idx, logic [31:0] val);
		if (idx == 0) rows_cfg = val[12:0];
		else if (idx == 1) cols_cfg = val[12:0];
		else if (idx == 2) k_cfg = val[19:0];
	endfunction

	static function longint angle_step(int n);
		longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return t[n];
	endfunction

	static function longint int_sqrt(longint unsigned v);
		longint unsigned root, bit_w;
		root = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= root + bit_w) begin
				v -= root + bit_w;
				root = (root >> 1) + bit_w;
			end else begin
				root >>= 1;
			end
			bit_w >>= 2;
		end
		return longint'(root);
	endfunction

	static function longint limit_of(logic [12:0] size);
		longint b;
		b = (size == 0) ? 0 : longint'(size) - 1;
		if (b > 4095) b = 4095;
		return b;
	endfunction

	// one axis: vectoring CORDIC for the angle, rotation CORDIC for the tangent
	function logic [11:0] bend_axis(longint pos, longint d, longint z8, longint hi,
			inout logic hit);
		longint vx, vy, ang, cx, cy, b, src, tx, off;
		vx = z8 * 256;
		vy = d * 65536;
		ang = 0;
		cx = 64'sd1 << 20;
		cy = 0;
		for (int n = 0; n < STEPS; n++) begin
			if (vy >= 0) begin
				tx = vx + (vy >>> n); vy = vy - (vx >>> n); ang += angle_step(n);
			end else begin
				tx = vx - (vy >>> n); vy = vy + (vx >>> n); ang -= angle_step(n);
			end
			vx = tx;
		end
		b = (ang * longint'(k_cfg)) >>> 16;
		while (b >= HALF_PI_FX) b -= PI_FX;
		while (b < -HALF_PI_FX) b += PI_FX;
		for (int n = 0; n < STEPS; n++) begin
			if (b >= 0) begin
				tx = cx - (cy >>> n); cy = cy + (cx >>> n); b -= angle_step(n);
			end else begin
				tx = cx + (cy >>> n); cy = cy - (cx >>> n); b += angle_step(n);
			end
			cx = tx;
		end
		if (cx <= 0) begin
			// tangent pole: offset is infinite
			src = (cy > 0) ? -1 : hi + 1;
		end else begin
			off = (z8 * cy) / cx;
			src = (pos * 256 - off + 128) >>> 8;
		end
		if (src < 0) begin
			hit = 1'b1; src = 0;
		end else if (src > hi) begin
			hit = 1'b1; src = hi;
		end
		return src[11:0];
	endfunction

	function void note_dest(logic [11:0] row, logic [11:0] col);
		coord_t e;
		longint mr, mc, rad, dr, dc, d2, r2, z8;
		logic hit;
		mr = longint'(rows_cfg >> 1);
		mc = longint'(cols_cfg >> 1);
		rad = (mr < mc) ? mr : mc;
		dr = longint'(row) - mr;
		dc = longint'(col) - mc;
		d2 = dr * dr + dc * dc;
		r2 = rad * rad;
		if (d2 < r2) begin
			hit = 1'b0;
			z8 = int_sqrt((r2 - d2) << 16);
			e.row = bend_axis(longint'(row), dr, z8, limit_of(rows_cfg), hit);
			e.col = bend_axis(longint'(col), dc, z8, limit_of(cols_cfg), hit);
			e.in_lens = 1'b1;
			e.clamped = hit;
		end else begin
			e.row = row; e.col = col; e.in_lens = 1'b0; e.clamped = 1'b0;
		end
		pending.push_back(e);
	endfunction

	function void check_src(logic [11:0] row, logic [11:0] col, logic ins, logic clp);
		coord_t e;
		if (pending.size() == 0) begin
			$error("unexpected src beat row=%0d col=%0d", row, col);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (row !== e.row) begin
			$error("src_row expected %0d actual %0d", e.row, row); errors++;
		end
		if (col !== e.col) begin
			$error("src_col expected %0d actual %0d", e.col, col); errors++;
		end
		if (ins !== e.in_lens) begin
			$error("inside_lens expected %0d actual %0d", e.in_lens, ins); errors++;
		end
		if (clp !== e.clamped) begin
			$error("clamped expected %0d actual %0d", e.clamped, clp); errors++;
		end
	endfunction

endclass

/* tb/tb_spherical_lens_source_coord.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spherical_lens_source_coord
// Drives destination beats through the lens mapper over several register
// settings, predicts every source coordinate and checks results in order.
// ----------------------------------------------------------------------------
module tb_spherical_lens_source_coord;
	import slsc_pkg::*;

	localparam int LATENCY = 85;
	localparam int WATCHDOG = 4000;

	logic        clk;
	logic        arst_n;
	logic        dest_valid;
	logic        dest_ready;
	logic [11:0] dest_row;
	logic [11:0] dest_col;
	logic        src_valid;
	logic        src_ready;
	logic [11:0] src_row;
	logic [11:0] src_col;
	logic        inside_lens;
	logic        clamped;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	slsc_scoreboard lens_sb;
	int  idle_cycles;
	bit  drive_done;
	bit  sink_stall_off;

	spherical_lens_source_coord dut (.*);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// predictor notes each accepted dest beat and checks each src beat
	always @(posedge clk) begin
		if (arst_n && dest_valid && dest_ready)
			lens_sb.note_dest(dest_row, dest_col);
		if (arst_n && src_valid && src_ready)
			lens_sb.check_src(src_row, src_col, inside_lens, clamped);
	end

	// watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((dest_valid && dest_ready) || (src_valid && src_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("[spherical_lens_source_coord] ERROR");
			$finish;
		end
	end

	// sink: random stall per result, sometimes none at all
	initial begin : sink
		int gap;
		src_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = sink_stall_off ? 0 : $urandom_range(0, 19);
			if ($urandom_range(0, 3) == 0) gap = 0;
			repeat (gap) begin
				@(posedge clk);
				src_ready <= 1'b0;
			end
			@(posedge clk);
			src_ready <= 1'b1;
			// hold ready until a beat leaves
			do @(posedge clk); while (!(src_valid && src_ready));
			src_ready <= 1'b0;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 4'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		lens_sb.set_reg(int'(idx), val);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// drop valid, wait for every prediction to drain, then let the pipe settle
	task automatic drain_pipe();
		dest_valid <= 1'b0;
		@(posedge clk);
		while (lens_sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// valid stays up after the beat is taken; the next call either replaces
	// the payload in the same step or drops valid for the gap
	task automatic send_dest(input logic [11:0] r, input logic [11:0] c, input int gap);
		if (gap > 0) begin
			dest_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dest_valid <= 1'b1; dest_row <= r; dest_col <= c;
		do @(posedge clk); while (!dest_ready);
	endtask

	task automatic set_image(input logic [12:0] nr, input logic [12:0] nc,
			input logic [19:0] k);
		drain_pipe();
		apb_write(REG_NUM_ROWS, 32'(nr));
		apb_write(REG_NUM_COLS, 32'(nc));
		apb_write(REG_LENS_FACTOR, {{12{k[19]}}, k});
	endtask

	// mostly points inside the image; some anywhere in range
	task automatic random_phase(input int n, input logic [12:0] nr,
			input logic [12:0] nc);
		logic [11:0] r, c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) != 0 && nr > 1 && nc > 1) begin
				r = 12'($urandom_range(0, (nr > 4096 ? 4096 : nr) - 1));
				c = 12'($urandom_range(0, (nc > 4096 ? 4096 : nc) - 1));
			end else begin
				r = 12'($urandom); c = 12'($urandom);
			end
			send_dest(r, c, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 19));
			if (i == n / 2 && n > 50) drain_pipe();  // sender holds off
		end
	endtask

	initial begin : main
		logic [12:0] nr, nc;
		logic [19:0] k;
		lens_sb = new();
		idle_cycles = 0;
		sink_stall_off = 0;
		drive_done = 0;
		arst_n = 1'b0;
		dest_valid = 1'b0; dest_row = '0; dest_col = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting is identity: centre, near corner, far corner
		send_dest(12'd256, 12'd256, 0);
		send_dest(12'd0, 12'd0, 0);
		send_dest(12'hFFF, 12'hFFF, 0);

		// strong bend, small image so clamping and the tangent pole show up
		set_image(13'd64, 13'd48, 20'h7FFFF);
		send_dest(12'd32, 12'd24, 0);
		send_dest(12'd10, 12'd24, 0);
		send_dest(12'd32, 12'd2, 0);
		send_dest(12'd55, 12'd40, 1);
		send_dest(12'd8, 12'd24, 0);
		set_image(13'd64, 13'd64, 20'h80000);
		send_dest(12'd32, 12'd1, 0);
		send_dest(12'd63, 12'd32, 0);
		send_dest(12'd5, 12'd50, 0);
		send_dest(12'd40, 12'd40, 0);
		// degenerate sizes: no lens at all
		set_image(13'd1, 13'd4096, 20'h10000);
		send_dest(12'd0, 12'd2048, 0);
		set_image(13'd0, 13'd0, 20'h10000);
		send_dest(12'd0, 12'd0, 0);
		// largest size, typical k, then a size beyond MAX_DIM
		set_image(13'd4096, 13'd4096, 20'h08000);
		send_dest(12'd2048, 12'd2048, 0);
		send_dest(12'd100, 12'd2048, 0);
		send_dest(12'd2048, 12'hFFF, 0);
		set_image(13'h1FFF, 13'd8191, 20'hF0000);
		send_dest(12'd1, 12'd4000, 0);

		for (int ph = 0; ph < 10; ph++) begin
			nr = 13'($urandom_range(2, 300));
			nc = 13'($urandom_range(2, 300));
			if (ph == 3) nr = 13'd4096;
			if (ph == 7) nc = 13'h1FFF;
			k = 20'($urandom);
			if (ph == 1) k = 20'h7FFFF;
			if (ph == 2) k = 20'h80000;
			sink_stall_off = (ph == 5);
			set_image(nr, nc, k);
			random_phase(155, nr, nc);
		end

		drain_pipe();
		drive_done = 1;
		if (lens_sb.errors == 0)
			$display("[spherical_lens_source_coord] OK");
		else
			$display("[spherical_lens_source_coord] ERROR");
		$finish;
	end

endmodule
